// ----- design/tfc_pkg.sv -----
`default_nettype none

package tfc_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
    localparam logic [31:0] FRAME_MAGIC = 32'h5344_5053;

    localparam int LEN_W        = 12;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_SEED    = 2'd1;
    localparam logic [1:0] CLS_PAYLOAD = 2'd2;
    localparam logic [1:0] CLS_TAG     = 2'd3;

    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_SHORT    = 3'd1;
    localparam logic [2:0] VERDICT_MAGIC    = 3'd2;
    localparam logic [2:0] VERDICT_MISMATCH = 3'd3;
    localparam logic [2:0] VERDICT_LONG     = 3'd4;
    localparam logic [2:0] VERDICT_TAG      = 3'd5;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [1:0]       cls;
        logic             emit;
        logic [2:0]       tag_idx;
        logic [2:0]       verdict;
        logic [LEN_W-1:0] length;
    } entry_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = FRAME_MAGIC[31:24];
            2'd1:    b = FRAME_MAGIC[23:16];
            2'd2:    b = FRAME_MAGIC[15:8];
            default: b = FRAME_MAGIC[7:0];
        endcase
        return b;
    endfunction

    // multiply by the fnv 64 prime, 2^40 + 0x1b3, as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// ----- design/tagged_frame_checker.sv -----
`default_nettype none

// checks length-prefixed frames arriving one byte per transaction: a 4-byte magic,
// a 32-bit big-endian length, the payload and an 8-byte little-endian fnv-1a 64 tag
// seeded from tag_seed (zero selects the standard offset basis; the seed is sampled
// when the last length byte reaches the hash unit). payload bytes stream out as they
// arrive unless the length exceeds MAX_PAYLOAD; the transaction on the last byte
// carries the verdict, and the streamed bytes are to be kept only on an ok verdict.
// a new byte is taken every clock while the queue has room, one byte per cycle, set
// by the one-step-per-cycle hash update in the back end; a byte passes the queue and
// the result register before it is offered. a two-entry queue between the classifier
// and the hash unit and a registered result let either side stall on its own.
// tag_seed lies at byte address 0 of the register port as one 64-bit register.
module tagged_frame_checker #(
    parameter int MAX_PAYLOAD = 2048
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    input  wire logic                        frame_valid,
    output logic                             frame_ready,
    input  wire logic [7:0]                  frame_byte,
    input  wire logic                        frame_last,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic                             item_kind,
    output logic [7:0]                       payload_byte,
    output logic [2:0]                       verdict,
    output logic [tfc_pkg::LEN_W-1:0]        payload_length
);

    logic [63:0]     tag_seed_reg, tag_seed_next;
    logic [63:0]     seed_eff;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    tfc_pkg::entry_t front_entry;
    tfc_pkg::entry_t q_entry;

    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? tag_seed_reg : 64'd0;

    always_comb
    begin
        tag_seed_next = tag_seed_reg;
        if (psel && penable && pwrite && paddr == 4'd0)
        begin
            tag_seed_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_seed_reg <= tfc_pkg::FNV_BASIS;
        end
        else
        begin
            tag_seed_reg <= tag_seed_next;
        end
    end

    assign seed_eff    = (tag_seed_reg != 64'd0) ? tag_seed_reg : tfc_pkg::FNV_BASIS;
    assign frame_ready = !q_full;
    assign push        = frame_valid && frame_ready;

    tfc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .entry      (front_entry)
    );

    tfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_entry)
    );

    tfc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed           (seed_eff),
        .q_valid        (q_valid),
        .q_data         (q_entry),
        .pop            (q_pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .item_kind      (item_kind),
        .payload_byte   (payload_byte),
        .verdict        (verdict),
        .payload_length (payload_length)
    );

endmodule

`default_nettype wire

// ----- design/tfc_front.sv -----
`default_nettype none

module tfc_front #(
    parameter int MAX_PAYLOAD = 2048
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire logic [7:0]      frame_byte,
    input  wire logic            frame_last,
    output tfc_pkg::entry_t      entry
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 16 + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD + 16);
    localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      len_reg, len_next;
    logic             magic_err_reg, magic_err_next;
    logic             ovf_reg, ovf_next;

    logic [32:0] idx_ext;
    logic [32:0] len_ext;
    logic [32:0] tag_off;
    logic        in_payload;
    logic        in_tag;

    assign idx_ext    = 33'(pos_reg);
    assign len_ext    = {1'b0, len_reg};
    assign in_payload = idx_ext < (len_ext + 33'd8);
    assign in_tag     = idx_ext < (len_ext + 33'd16);
    assign tag_off    = idx_ext - len_ext - 33'd8;

    always_comb
    begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        magic_err_next = magic_err_reg;
        ovf_next       = ovf_reg;

        entry          = '0;
        entry.data     = frame_byte;
        entry.last     = frame_last;
        entry.cls      = tfc_pkg::CLS_NONE;

        if (!ovf_reg)
        begin
            if (pos_reg < POS_W'(4))
            begin
                if (frame_byte != tfc_pkg::magic_byte(pos_reg[1:0]))
                begin
                    magic_err_next = 1'b1;
                end
            end
            else if (pos_reg < POS_W'(8))
            begin
                len_next = {len_reg[23:0], frame_byte};
                if (pos_reg == POS_W'(7))
                begin
                    entry.cls = tfc_pkg::CLS_SEED;
                end
            end
            else if (in_payload)
            begin
                entry.cls  = tfc_pkg::CLS_PAYLOAD;
                entry.emit = (len_reg <= MAX_LEN);
            end
            else if (in_tag)
            begin
                entry.cls     = tfc_pkg::CLS_TAG;
                entry.tag_idx = tag_off[2:0];
            end
        end

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end

        // verdict as far as the front can tell; tag check finishes in the back
        if (!ovf_next && pos_next < POS_W'(16))
        begin
            entry.verdict = tfc_pkg::VERDICT_SHORT;
        end
        else if (magic_err_next)
        begin
            entry.verdict = tfc_pkg::VERDICT_MAGIC;
        end
        else if (len_next > MAX_LEN)
        begin
            entry.verdict = tfc_pkg::VERDICT_LONG;
        end
        else if (ovf_next || ({1'b0, len_next} + 33'd16) != 33'(pos_next))
        begin
            entry.verdict = tfc_pkg::VERDICT_MISMATCH;
        end
        else
        begin
            entry.verdict = tfc_pkg::VERDICT_OK;
        end
        entry.length = len_next[tfc_pkg::LEN_W-1:0];

        if (frame_last)
        begin
            pos_next       = '0;
            len_next       = '0;
            magic_err_next = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            magic_err_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else if (push)
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            magic_err_reg <= magic_err_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tfc_queue.sv -----
`default_nettype none

module tfc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tfc_pkg::entry_t wr_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output tfc_pkg::entry_t      rd_data
);

    tfc_pkg::entry_t                 mem_reg [tfc_pkg::QUEUE_DEPTH];
    logic [tfc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [tfc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [tfc_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == tfc_pkg::QUEUE_CNT_W'(tfc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tfc_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tfc_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tfc_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tfc_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tfc_pkg::QUEUE_CNT_W'(tfc_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ----- design/tfc_back.sv -----
`default_nettype none

module tfc_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [63:0]              seed,
    input  wire logic                     q_valid,
    input  wire tfc_pkg::entry_t          q_data,
    output logic                          pop,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic                          item_kind,
    output logic [7:0]                    payload_byte,
    output logic [2:0]                    verdict,
    output logic [tfc_pkg::LEN_W-1:0]     payload_length
);

    logic [63:0]               hash_reg, hash_next;
    logic                      tag_err_reg, tag_err_next;
    logic                      valid_reg, valid_next;
    logic                      kind_reg, kind_next;
    logic [7:0]                byte_reg, byte_next;
    logic [2:0]                verdict_reg, verdict_next;
    logic [tfc_pkg::LEN_W-1:0] length_reg, length_next;
    logic                      tag_miss;

    assign pop      = q_valid && (!valid_reg || result_ready);
    assign tag_miss = (q_data.cls == tfc_pkg::CLS_TAG)
                      && (hash_reg[{q_data.tag_idx, 3'b000} +: 8] != q_data.data);

    always_comb
    begin
        hash_next    = hash_reg;
        tag_err_next = tag_err_reg;
        valid_next   = valid_reg && !result_ready;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        verdict_next = verdict_reg;
        length_next  = length_reg;

        if (pop)
        begin
            case (q_data.cls)
                tfc_pkg::CLS_SEED:    hash_next = seed;
                tfc_pkg::CLS_PAYLOAD: hash_next = tfc_pkg::fnv_step(hash_reg, q_data.data);
                tfc_pkg::CLS_TAG:     tag_err_next = tag_err_reg || tag_miss;
                default:              hash_next = hash_reg;
            endcase

            if (q_data.last)
            begin
                valid_next   = 1'b1;
                kind_next    = 1'b1;
                byte_next    = 8'd0;
                verdict_next = q_data.verdict;
                if (q_data.verdict == tfc_pkg::VERDICT_OK && (tag_err_reg || tag_miss))
                begin
                    verdict_next = tfc_pkg::VERDICT_TAG;
                end
                length_next  = (verdict_next == tfc_pkg::VERDICT_OK) ? q_data.length : '0;
                tag_err_next = 1'b0;
            end
            else if (q_data.cls == tfc_pkg::CLS_PAYLOAD && q_data.emit)
            begin
                valid_next   = 1'b1;
                kind_next    = 1'b0;
                byte_next    = q_data.data;
                verdict_next = tfc_pkg::VERDICT_OK;
                length_next  = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg    <= hash_next;
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        verdict_reg <= verdict_next;
        length_reg  <= length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_err_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            tag_err_reg <= tag_err_next;
            valid_reg   <= valid_next;
        end
    end

    assign result_valid   = valid_reg;
    assign item_kind      = kind_reg;
    assign payload_byte   = byte_reg;
    assign verdict        = verdict_reg;
    assign payload_length = length_reg;

`ifndef ASSERT_OFF
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data.last |=> valid_reg && kind_reg)
        else $error("end of frame without verdict");

    a_front_reject_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data.last && q_data.verdict != tfc_pkg::VERDICT_OK
        |=> verdict_reg == $past(q_data.verdict))
        else $error("front verdict overridden");

    a_byte_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !kind_reg |-> verdict_reg == tfc_pkg::VERDICT_OK && length_reg == '0)
        else $error("payload item carries verdict fields");

    a_tag_err_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data.last |=> !tag_err_reg)
        else $error("tag error survives end of frame");
`endif

endmodule

`default_nettype wire
